@@ sv/lbal_pkg.sv @@
// ----------------------------------------------------------------------------
// lbal_pkg: shared types and constants for the server select balancer
// Table sizes, field codes, register map and the scoring function.
// ----------------------------------------------------------------------------
package lbal_pkg;

  localparam int MaxServers = 16;
  localparam int IdxW       = $clog2(MaxServers);
  localparam int CntW       = $clog2(MaxServers + 1);
  localparam int ScoreW     = 16;   // max weight*409 times 16 entries fits
  localparam int DivNumW    = 32;
  localparam int DivDenW    = ScoreW;

  localparam logic [3:0]  MaxWeight   = 4'd10;
  localparam logic [8:0]  ScoreFactor = 9'd409;
  localparam logic [31:0] RetryReset  = 32'd600000;
  localparam logic [31:0] OvlReset    = 32'd4096;

  // item kinds
  localparam logic [1:0] KindSelect    = 2'd0;
  localparam logic [1:0] KindRegister  = 2'd1;
  localparam logic [1:0] KindDown      = 2'd2;
  localparam logic [1:0] KindHeartbeat = 2'd3;

  // balance rules
  localparam logic [1:0] RuleUnset    = 2'd0;
  localparam logic [1:0] RuleRound    = 2'd1;
  localparam logic [1:0] RuleWeighted = 2'd2;
  localparam logic [1:0] RuleIpHash   = 2'd3;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] RegRule  = 2'd0;
  localparam logic [1:0] RegRetry = 2'd1;
  localparam logic [1:0] RegOvl   = 2'd2;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivDenW-1:0] rem;
  } div_rsp_t;

  function automatic logic [ScoreW-1:0] score(input logic [3:0] weight,
                                              input logic down,
                                              input logic ovl,
                                              input logic [31:0] backlog);
    logic [12:0] base;
    logic [ScoreW-1:0] s;
    base = 13'(weight * ScoreFactor);
    s    = '0;
    if (!down && !ovl && ({19'd0, base} > backlog)) begin
      s = ScoreW'(base - backlog[12:0]);
    end
    return s;
  endfunction

endpackage

@@ sv/lbal_div.sv @@
// ----------------------------------------------------------------------------
// lbal_div: iterative remainder unit
// Restoring division, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module lbal_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lbal_pkg::div_req_t  req_i,
  output lbal_pkg::div_rsp_t  rsp_o
);
  import lbal_pkg::*;

  localparam int StepW = $clog2(DivNumW + 1);

  logic               busy_q, busy_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic [DivNumW-1:0] num_q, num_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic               done_q, done_d;
  logic [DivDenW:0]   trial;

  assign trial = {rem_q, num_q[DivNumW-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = StepW'(DivNumW);
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[DivNumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = DivDenW'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[DivDenW-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ sv/server_select_balancer.sv @@
// ----------------------------------------------------------------------------
// server_select_balancer: server table with round robin, weighted and IP hash
// Table updates: input ready again the next cycle. Select: round robin scans
// on from the last choice, one entry a cycle, up to server_count entries;
// weighted sums scores, then the remainder unit, then scans; IP hash uses the
// remainder unit; empty table, unset rule or bad address answer directly.
// One item in flight; input stays blocked until the result transfers.
// Reset (async, low): count and last choice cleared, registers to defaults.
// ----------------------------------------------------------------------------
module server_select_balancer (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] server_index, [7:4] new_weight, [39:8] backlog_value,
  // [71:40] source_ip, [72] ip_valid, [104:73] random_word, [152:105] now_ms
  input  logic [159:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,   // [1:0] kind
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata,   // [3:0] chosen_server
  output logic         m_axis_tuser,   // [0] found
  // config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import lbal_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRound = 3'd1;
  localparam logic [2:0] StWSum  = 3'd2;
  localparam logic [2:0] StWDiv  = 3'd3;
  localparam logic [2:0] StWFind = 3'd4;
  localparam logic [2:0] StIpDiv = 3'd5;

  // config registers
  logic [1:0]  rule_q;
  logic [31:0] retry_q, ovl_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q  <= RuleUnset;
      retry_q <= RetryReset;
      ovl_q   <= OvlReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegRule:  rule_q  <= pwdata[1:0];
        RegRetry: retry_q <= pwdata;
        RegOvl:   ovl_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegRule:  prdata = {30'd0, rule_q};
      RegRetry: prdata = retry_q;
      RegOvl:   prdata = ovl_q;
      default:  prdata = '0;
    endcase
  end

  // input unpack
  logic [1:0]  in_kind;
  logic [3:0]  in_sidx, in_wgt;
  logic [31:0] in_backlog, in_ip, in_rnd;
  logic        in_ipok;
  logic [47:0] in_now;

  assign in_kind    = s_axis_tuser;
  assign in_sidx    = s_axis_tdata[3:0];
  assign in_wgt     = s_axis_tdata[7:4];
  assign in_backlog = s_axis_tdata[39:8];
  assign in_ip      = s_axis_tdata[71:40];
  assign in_ipok    = s_axis_tdata[72];
  assign in_rnd     = s_axis_tdata[104:73];
  assign in_now     = s_axis_tdata[152:105];

  // server table: flops, one sequencer-chosen read per cycle
  logic [3:0]  weight_q  [MaxServers];
  logic        down_q    [MaxServers];
  logic [47:0] dtime_q   [MaxServers];
  logic [31:0] backlog_q [MaxServers];
  logic        ovlf_q    [MaxServers];

  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] last_q, last_d;

  // sequencer
  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] step_q, step_d;
  logic [ScoreW-1:0] tot_q, tot_d;
  logic [ScoreW-1:0] r_q, r_d;
  logic [31:0]     rnd_q, rnd_d;
  logic [47:0]     now_q, now_d;

  logic            ov_q, ov_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] chosen_q, chosen_d;

  logic accept;
  assign s_axis_tready = (state_q == StIdle) && !ov_q;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // round robin candidate
  logic [CntW-1:0] nxt_wide;
  logic [IdxW-1:0] nidx;
  logic [48:0]     retry_at;
  logic            usable;
  assign nxt_wide = CntW'(idx_q) + 1'b1;
  assign nidx     = (nxt_wide >= count_q) ? '0 : nxt_wide[IdxW-1:0];
  assign retry_at = {1'b0, dtime_q[nidx]} + {17'd0, retry_q};
  assign usable   = (weight_q[nidx] != 4'd0) &&
                    (!down_q[nidx] || ({1'b0, now_q} >= retry_at));

  // weighted score at idx
  logic [ScoreW-1:0] cur_score, cum;
  assign cur_score = score(weight_q[idx_q], down_q[idx_q], ovlf_q[idx_q],
                           backlog_q[idx_q]);
  assign cum       = tot_q + cur_score;

  div_req_t div_req;
  div_rsp_t div_rsp;

  lbal_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  logic last_idx;
  assign last_idx = (CntW'(idx_q) + 1'b1) == count_q;

  // table write controls
  logic            tw_reg, tw_down, tw_hb, tw_clr;
  logic [IdxW-1:0] tw_idx;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    step_d   = step_q;
    tot_d    = tot_q;
    r_d      = r_q;
    rnd_d    = rnd_q;
    now_d    = now_q;
    count_d  = count_q;
    last_d   = last_q;
    ov_d     = ov_q;
    found_d  = found_q;
    chosen_d = chosen_q;
    div_req  = '0;
    tw_reg   = 1'b0;
    tw_down  = 1'b0;
    tw_hb    = 1'b0;
    tw_clr   = 1'b0;
    tw_idx   = in_sidx;

    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          case (in_kind)
            KindRegister: begin
              if (in_wgt <= MaxWeight && count_q < CntW'(MaxServers)) begin
                tw_reg  = 1'b1;
                tw_idx  = count_q[IdxW-1:0];
                count_d = count_q + 1'b1;
                last_d  = '0;
              end
            end
            KindDown: begin
              tw_down = CntW'(in_sidx) < count_q;
            end
            KindHeartbeat: begin
              tw_hb = CntW'(in_sidx) < count_q;
            end
            default: begin
              // select: quick answers land straight in the output register
              rnd_d    = in_rnd;
              now_d    = in_now;
              found_d  = count_q != '0;
              chosen_d = '0;
              if (count_q == '0) begin
                ov_d = 1'b1;
              end else begin
                case (rule_q)
                  RuleRound: begin
                    idx_d   = last_q;
                    step_d  = '0;
                    state_d = StRound;
                  end
                  RuleWeighted: begin
                    idx_d   = '0;
                    tot_d   = '0;
                    state_d = StWSum;
                  end
                  RuleIpHash: begin
                    if (in_ipok) begin
                      div_req.start = 1'b1;
                      div_req.num   = in_ip;
                      div_req.den   = DivDenW'(count_q);
                      state_d       = StIpDiv;
                    end else begin
                      ov_d = 1'b1;
                    end
                  end
                  default: ov_d = 1'b1;
                endcase
              end
            end
          endcase
        end
      end

      StRound: begin
        if (usable) begin
          tw_clr   = 1'b1;
          tw_idx   = nidx;
          last_d   = nidx;
          chosen_d = nidx;
          ov_d     = 1'b1;
          state_d  = StIdle;
        end else begin
          idx_d  = nidx;
          step_d = step_q + 1'b1;
          if (step_q + 1'b1 == count_q) begin
            ov_d    = 1'b1;
            state_d = StIdle;
          end
        end
      end

      StWSum: begin
        tot_d = cum;
        idx_d = idx_q + 1'b1;
        if (last_idx) begin
          if (cum == '0) begin
            ov_d    = 1'b1;
            state_d = StIdle;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = rnd_q;
            div_req.den   = cum;
            state_d       = StWDiv;
          end
        end
      end

      StWDiv: begin
        if (div_rsp.done) begin
          r_d     = div_rsp.rem;
          idx_d   = '0;
          tot_d   = '0;
          state_d = StWFind;
        end
      end

      StWFind: begin
        tot_d = cum;
        idx_d = idx_q + 1'b1;
        if (cum > r_q) begin
          last_d   = idx_q;
          chosen_d = idx_q;
          ov_d     = 1'b1;
          state_d  = StIdle;
        end else if (last_idx) begin
          ov_d    = 1'b1;
          state_d = StIdle;
        end
      end

      StIpDiv: begin
        if (div_rsp.done) begin
          last_d   = div_rsp.rem[IdxW-1:0];
          chosen_d = div_rsp.rem[IdxW-1:0];
          ov_d     = 1'b1;
          state_d  = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      last_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      last_q  <= last_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    step_q   <= step_d;
    tot_q    <= tot_d;
    r_q      <= r_d;
    rnd_q    <= rnd_d;
    now_q    <= now_d;
    found_q  <= found_d;
    chosen_q <= chosen_d;
    if (tw_reg) begin
      weight_q[tw_idx]  <= in_wgt;
      down_q[tw_idx]    <= 1'b0;
      dtime_q[tw_idx]   <= '0;
      backlog_q[tw_idx] <= '0;
      ovlf_q[tw_idx]    <= 1'b0;
    end
    if (tw_down) begin
      down_q[tw_idx]  <= 1'b1;
      dtime_q[tw_idx] <= in_now;
    end
    if (tw_hb) begin
      down_q[tw_idx]    <= 1'b0;
      backlog_q[tw_idx] <= in_backlog;
      ovlf_q[tw_idx]    <= in_backlog > ovl_q;
    end
    if (tw_clr) begin
      down_q[tw_idx] <= 1'b0;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = found_q;
  assign m_axis_tdata  = {{(8 - IdxW){1'b0}}, chosen_q};

endmodule

@@ tb/server_select_balancer_tb.sv @@
// ----------------------------------------------------------------------------
// server_select_balancer_tb: self-checking bench for the server select balancer
// Drives table updates and select requests over the input stream, predicts
// each selection from a local copy of the server table and compares the
// result stream transfer by transfer, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module server_select_balancer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbal_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;   // index, weight, backlog, ip, ip_ok, rnd, now
  logic [1:0]   s_axis_tuser = '0;   // [1:0] kind
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;        // [3:0] chosen_server
  logic         m_axis_tuser;        // [0] found
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  server_select_balancer dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic       found;
    logic [3:0] server;
  } pick_t;

  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  sidx;
    logic [3:0]  wgt;
    logic [31:0] backlog;
    logic [31:0] ip;
    logic        ip_ok;
    logic [31:0] rnd;
    logic [47:0] now;
  } req_t;

  // predicted table and registers
  logic [1:0]  rule_q;
  logic [31:0] retry_q, ovl_q;
  int unsigned count_q, last_q;
  logic [3:0]  weight_q [MaxServers];
  logic        down_q   [MaxServers];
  logic [47:0] downt_q  [MaxServers];
  logic [31:0] blog_q   [MaxServers];
  logic        over_q   [MaxServers];

  pick_t picks_pending[$];
  int    errors = 0;
  longint cycles = 0;
  int    send_idle_pct = 0, recv_stall_pct = 0;
  bit    hold_recv = 1'b0;
  logic [47:0] clock_ms = 48'd1000;

  // --- predictor: updates the table and returns a pick for selects ---
  function automatic bit predict_pick(input req_t r, output pick_t p);
    longint unsigned cum[MaxServers];
    longint unsigned total, base, rr;
    int unsigned idx;
    p = '0;
    case (r.kind)
      KindRegister: begin
        if (r.wgt <= MaxWeight && count_q < MaxServers) begin
          weight_q[count_q] = r.wgt; down_q[count_q] = 0; downt_q[count_q] = 0;
          blog_q[count_q] = 0; over_q[count_q] = 0;
          count_q++; last_q = 0;
        end
        return 0;
      end
      KindDown: begin
        if (r.sidx < count_q) begin
          down_q[r.sidx] = 1; downt_q[r.sidx] = r.now;
        end
        return 0;
      end
      KindHeartbeat: begin
        if (r.sidx < count_q) begin
          down_q[r.sidx] = 0; blog_q[r.sidx] = r.backlog;
          over_q[r.sidx] = r.backlog > ovl_q;
        end
        return 0;
      end
      default: ;
    endcase
    if (count_q == 0) return 1;
    p.found = 1;
    case (rule_q)
      RuleRound: begin
        idx = last_q;
        for (int k = 0; k < count_q; k++) begin
          idx++;
          if (idx >= count_q) idx = 0;
          if (weight_q[idx] != 0) begin
            if (down_q[idx] && 49'(r.now) >= 49'(downt_q[idx]) + 49'(retry_q))
              down_q[idx] = 0;
            if (!down_q[idx]) begin
              last_q = idx; p.server = idx[3:0];
              break;
            end
          end
        end
      end
      RuleWeighted: begin
        total = 0;
        for (int i = 0; i < count_q; i++) begin
          base = weight_q[i] * 409;
          if (!down_q[i] && !over_q[i] && base > blog_q[i]) total += base - blog_q[i];
          cum[i] = total;
        end
        if (total != 0) begin
          rr = r.rnd % total;
          for (int i = 0; i < count_q; i++)
            if (cum[i] > rr) begin
              last_q = i; p.server = i[3:0];
              break;
            end
        end
      end
      RuleIpHash: begin
        if (r.ip_ok) begin
          last_q = r.ip % count_q; p.server = last_q[3:0];
        end
      end
      default: ;
    endcase
    return 1;
  endfunction

  // --- cycle limit ---
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --- receiver: random stalls, plus a long hold-off when requested ---
  always @(posedge clk_i) begin
    if (rst_ni)
      m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
  end

  // --- result checker ---
  always @(posedge clk_i) begin
    pick_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{found: m_axis_tuser, server: m_axis_tdata[3:0]};
      if (picks_pending.size() == 0) begin
        $display("%0t: unexpected result transfer found=%0d server=%0d",
                 $time, got.found, got.server);
        errors++;
      end else begin
        want = picks_pending.pop_front();
        if (got.found !== want.found)
          $display("%0t: found mismatch expected %0d actual %0d", $time, want.found,
                   got.found);
        if (got.server !== want.server)
          $display("%0t: server mismatch expected %0d actual %0d", $time, want.server,
                   got.server);
        if (got !== want) errors++;
      end
    end
  end

  // --- send one item on the input stream; valid stays up between items unless an idle gap is drawn ---
  task automatic send_item(input req_t r);
    pick_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.kind;
    s_axis_tdata  <= {7'd0, r.now, r.rnd, r.ip_ok, r.ip, r.backlog, r.wgt, r.sidx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_pick(r, p)) picks_pending.insert(picks_pending.size(), p);
  endtask

  // --- wait until every pick is back, then let the block settle ---
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (picks_pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      RegRule:  rule_q  = val[1:0];
      RegRetry: retry_q = val;
      default:  ovl_q   = val;
    endcase
  endtask

  function automatic req_t rand_item(input int sel_pct);
    req_t r;
    int pct = $urandom_range(99);
    r.kind    = pct < sel_pct ? KindSelect : 2'($urandom_range(3));
    r.sidx    = $urandom_range(99) < 85 ? 4'($urandom_range(count_q > 0 ? count_q - 1 : 0))
                                        : 4'($urandom);
    r.wgt     = $urandom_range(99) < 85 ? 4'($urandom_range(10)) : 4'($urandom);
    case ($urandom_range(3))
      0: r.backlog = $urandom;
      1: r.backlog = ovl_q + $urandom_range(2) - 1;
      default: r.backlog = $urandom_range(4500);
    endcase
    r.ip      = $urandom;
    r.ip_ok   = $urandom_range(99) < 80;
    r.rnd     = $urandom;
    // time mostly advances; sometimes jumps far or far back
    clock_ms += $urandom_range(300000);
    r.now     = $urandom_range(99) < 5 ? 48'({$urandom, $urandom}) : clock_ms;
    return r;
  endfunction

  // directed: empty table, extreme fields, every kind and special case
  task automatic test_directed();
    req_t r;
    r = '{KindSelect, 0, 0, 0, 0, 0, 0, 0};
    send_item(r);                                  // empty table
    r.kind = KindHeartbeat; r.sidx = 4'hf; send_item(r); // unknown server
    r.kind = KindRegister; r.wgt = 4'd11; send_item(r); // weight above ten
    r.wgt = 4'hf; send_item(r);
    for (int i = 0; i < 17; i++) begin             // fill and overfill
      r.kind = KindRegister; r.wgt = (i == 3) ? 4'd0 : 4'(i % 11);
      send_item(r);
    end
    r = '{KindSelect, 4'hf, 4'hf, '1, '1, 1'b1, '1, '1};
    send_item(r);
    drain();
    write_reg(RegRule, RuleIpHash);
    send_item(r); r.ip_ok = 0; send_item(r);
    r.kind = KindDown; r.sidx = 4'd15; r.now = 48'd5; send_item(r);
    r.kind = KindHeartbeat; r.sidx = 4'd7; r.backlog = '1; send_item(r);
    drain();
  endtask

  // random phase with a given rule and idle and stall mix
  task automatic test_random(input logic [1:0] rule, input int n,
                             input int idle, input int stall);
    drain();
    write_reg(RegRule, rule);
    send_idle_pct = idle; recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_item(rand_item(55));
    drain();
  endtask

  // back-pressure: round robin selects sent while the receiver is held off; the
  // table only grows, so this runs on the table left by the earlier phases
  task automatic test_pressure();
    req_t r;
    drain();
    write_reg(RegRule, RuleRound);
    send_idle_pct = 0; recv_stall_pct = 0;
    fork
      begin
        hold_recv <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_recv <= 1'b0;
      end
      for (int i = 0; i < 20; i++) begin
        r = rand_item(100);
        send_item(r);
      end
    join
    drain();
  endtask

  initial begin
    rule_q = RuleUnset; retry_q = RetryReset; ovl_q = OvlReset;
    count_q = 0; last_q = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(RegRetry, 32'd0);
    write_reg(RegOvl, 32'd0);
    test_random(RuleRound,    150, 0, 0);
    test_random(RuleWeighted, 150, 65, 0);
    write_reg(RegRetry, 32'hffff_ffff);
    write_reg(RegOvl, 32'hffff_ffff);
    test_random(RuleIpHash,   150, 0, 65);
    test_random(RuleRound,    150, 8, 8);
    write_reg(RegRetry, 32'd200000);
    write_reg(RegOvl, 32'd3000);
    test_random(RuleWeighted, 200, 0, 0);
    test_random(RuleRound,    150, 65, 65);
    test_random(RuleUnset,     60, 8, 8);
    test_random(RuleWeighted, 150, 8, 8);
    test_pressure();
    drain();
    if (errors == 0 && picks_pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lbal_pkg.sv
sv/lbal_div.sv
sv/server_select_balancer.sv
tb/server_select_balancer_tb.sv
